/* design/assert_macros.svh */
// Assertion macros shared by the modules of the color band mask block.
// Each one samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression holds at every edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/cbmd_pkg.sv */
`default_nettype none

package cbmd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
    localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);

    localparam int SIZE_REG_W = 11;
    localparam int CHAN_W     = 8;
    localparam int INDEX_W    = 3;

    localparam logic [INDEX_W-1:0] REG_WIDTH     = 3'd0;
    localparam logic [INDEX_W-1:0] REG_HEIGHT    = 3'd1;
    localparam logic [INDEX_W-1:0] REG_B_CENTER  = 3'd2;
    localparam logic [INDEX_W-1:0] REG_G_CENTER  = 3'd3;
    localparam logic [INDEX_W-1:0] REG_R_CENTER  = 3'd4;
    localparam logic [INDEX_W-1:0] REG_B_TOL     = 3'd5;
    localparam logic [INDEX_W-1:0] REG_G_TOL     = 3'd6;
    localparam logic [INDEX_W-1:0] REG_R_TOL     = 3'd7;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;
    localparam int RESET_CENTER = 128;
    localparam int RESET_TOL    = 50;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int SUM_W       = 23;
    localparam int COEF_B      = 1868;
    localparam int COEF_G      = 9617;
    localparam int COEF_R      = 4899;
    localparam int GRAY_ROUND  = 8192;
    localparam int GRAY_SHIFT  = 14;
    localparam int MASK_THRESH = 128;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int LINE_W = 2;
    localparam int WIN_W  = 9;

    typedef struct packed {
        logic [CHAN_W-1:0] b_center;
        logic [CHAN_W-1:0] g_center;
        logic [CHAN_W-1:0] r_center;
        logic [CHAN_W-1:0] b_tol;
        logic [CHAN_W-1:0] g_tol;
        logic [CHAN_W-1:0] r_tol;
    } cbmd_band_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  width;
        logic [HEIGHT_W-1:0] height;
    } cbmd_size_t;

    typedef struct packed {
        logic kind;
        logic bit_m;
    } cbmd_item_t;

endpackage

`default_nettype wire

/* design/cbmd_ram.sv */
`default_nettype none

module cbmd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* design/cbmd_queue.sv */
`default_nettype none
`include "assert_macros.svh"

module cbmd_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cbmd_pkg::cbmd_item_t push_item,
    output logic                     push_ready,
    input  wire logic                pop,
    output logic                     pop_valid,
    output cbmd_pkg::cbmd_item_t     pop_item
);

    cbmd_pkg::cbmd_item_t entry_reg [cbmd_pkg::QDEPTH];
    logic [cbmd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cbmd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cbmd_pkg::QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        push_ready  = count_reg != cbmd_pkg::QCNT_W'(cbmd_pkg::QDEPTH);
        pop_valid   = count_reg != '0;
        pop_item    = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ASSERT_IMPL(a_pop_nonempty, pop, count_reg != '0, "queue popped while empty")
    `ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "queue count lost a push")

endmodule

`default_nettype wire

/* design/cbmd_front.sv */
`default_nettype none

module cbmd_front (
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [23:0]          s_tdata,
    input  wire logic [0:0]           s_tuser,
    input  wire cbmd_pkg::cbmd_band_t band,
    input  wire logic                 q_ready,
    output logic                      q_push,
    output cbmd_pkg::cbmd_item_t      q_item
);

    function automatic logic [cbmd_pkg::CHAN_W-1:0] band_keep(
        input logic [cbmd_pkg::CHAN_W-1:0] v,
        input logic [cbmd_pkg::CHAN_W-1:0] center,
        input logic [cbmd_pkg::CHAN_W-1:0] tol
    );
        logic signed [cbmd_pkg::CHAN_W+1:0] lo;
        logic signed [cbmd_pkg::CHAN_W+1:0] hi;
        logic signed [cbmd_pkg::CHAN_W+1:0] x;
        lo = $signed({2'b00, center}) - $signed({2'b00, tol});
        hi = $signed({2'b00, center}) + $signed({2'b00, tol});
        x  = $signed({2'b00, v});
        return (x > lo && x <= hi) ? v : '0;
    endfunction

    logic [cbmd_pkg::CHAN_W-1:0] b_keep, g_keep, r_keep;
    logic [cbmd_pkg::SUM_W-1:0]  sum;
    logic [cbmd_pkg::SUM_W-1:0]  gray;

    always_comb
    begin
        b_keep = band_keep(s_tdata[7:0], band.b_center, band.b_tol);
        g_keep = band_keep(s_tdata[15:8], band.g_center, band.g_tol);
        r_keep = band_keep(s_tdata[23:16], band.r_center, band.r_tol);
        sum = cbmd_pkg::SUM_W'(b_keep) * cbmd_pkg::SUM_W'(cbmd_pkg::COEF_B)
            + cbmd_pkg::SUM_W'(g_keep) * cbmd_pkg::SUM_W'(cbmd_pkg::COEF_G)
            + cbmd_pkg::SUM_W'(r_keep) * cbmd_pkg::SUM_W'(cbmd_pkg::COEF_R)
            + cbmd_pkg::SUM_W'(cbmd_pkg::GRAY_ROUND);
        gray = sum >> cbmd_pkg::GRAY_SHIFT;
        s_tready     = q_ready;
        q_push       = s_tvalid && q_ready;
        q_item.kind  = s_tuser[0];
        q_item.bit_m = gray > cbmd_pkg::SUM_W'(cbmd_pkg::MASK_THRESH);
    end

endmodule

`default_nettype wire

/* design/cbmd_back.sv */
`default_nettype none
`include "assert_macros.svh"

module cbmd_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cbmd_pkg::cbmd_size_t size,
    input  wire logic                 restart,
    input  wire logic                 q_valid,
    input  wire cbmd_pkg::cbmd_item_t q_item,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic                      mask,
    output logic                      frame_end
);

    logic [cbmd_pkg::COL_W-1:0]  ci_reg, ci_next;
    logic [cbmd_pkg::ROW_W-1:0]  ri_reg, ri_next;
    logic [cbmd_pkg::WIN_W-1:0]  win_reg, win_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        mask_reg, mask_next;
    logic                        last_reg, last_next;
    logic                        bypass_valid_reg, bypass_valid_next;
    logic [cbmd_pkg::LINE_W-1:0] bypass_data_reg;

    logic                        ram_we;
    logic [cbmd_pkg::COL_W-1:0]  ram_waddr;
    logic [cbmd_pkg::LINE_W-1:0] ram_wdata;
    logic [cbmd_pkg::LINE_W-1:0] ram_rdata;

    logic [cbmd_pkg::COL_W-1:0]  wm1;
    logic [cbmd_pkg::ROW_W-1:0]  hx;
    logic [cbmd_pkg::ROW_W-1:0]  hm1;
    logic                        out_ready;
    logic                        active;
    logic                        step;
    logic                        m;
    logic [cbmd_pkg::LINE_W-1:0] old;
    logic [2:0]                  col;
    logic [cbmd_pkg::WIN_W-1:0]  win_adv;
    logic                        ci_nz;
    logic                        ci_last;
    logic                        produce;
    logic [cbmd_pkg::ROW_W-1:0]  ro;
    logic [cbmd_pkg::COL_W-1:0]  co;
    logic [2:0]                  rows;
    logic [2:0]                  acc;
    logic                        last;

    cbmd_ram #(
        .WIDTH (cbmd_pkg::LINE_W),
        .DEPTH (cbmd_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ci_next),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wm1       = cbmd_pkg::COL_W'(size.width - cbmd_pkg::WIDTH_W'(1));
        hx        = cbmd_pkg::ROW_W'(size.height);
        hm1       = hx - cbmd_pkg::ROW_W'(1);
        out_ready = !out_valid_reg || m_tready;
        active    = (q_item.kind == cbmd_pkg::KIND_DRAIN) ? (ri_reg >= hx) : (ri_reg < hx);
        step      = q_valid && out_ready && active;
        m         = (q_item.kind == cbmd_pkg::KIND_PIXEL) ? q_item.bit_m : 1'b0;
        old       = bypass_valid_reg ? bypass_data_reg : ram_rdata;

        // Line bits: bit 0 is one row up, bit 1 two rows up.
        col     = {m, old[0], old[1]};
        win_adv = {win_reg[5:0], col};
        ci_nz   = ci_reg != '0;
        ci_last = ci_reg == wm1;
        produce = (ri_reg >= cbmd_pkg::ROW_W'(2)) || (ri_reg == cbmd_pkg::ROW_W'(1) && ci_nz);
        ro      = ci_nz ? ri_reg - cbmd_pkg::ROW_W'(1) : ri_reg - cbmd_pkg::ROW_W'(2);
        co      = ci_nz ? ci_reg - cbmd_pkg::COL_W'(1) : wm1;
        rows    = {ro < hm1, 1'b1, ro != '0};
        acc     = win_adv[5:3] & rows;
        if (co != wm1)
        begin
            acc = acc | (win_adv[2:0] & rows);
        end
        if (co != '0)
        begin
            acc = acc | (win_adv[8:6] & rows);
        end
        last = (ro == hm1) && (co == wm1);

        // A drain that produced nothing stays at the head and steps again.
        q_pop = q_valid && out_ready
              && (!active || produce || q_item.kind == cbmd_pkg::KIND_PIXEL);

        ram_we    = step;
        ram_waddr = ci_reg;
        ram_wdata = {old[0], m};

        ci_next        = ci_reg;
        ri_next        = ri_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mask_next      = mask_reg;
        last_next      = last_reg;
        if (restart)
        begin
            ci_next  = '0;
            ri_next  = '0;
            win_next = '0;
        end
        else if (step)
        begin
            if (produce && last)
            begin
                ci_next  = '0;
                ri_next  = '0;
                win_next = '0;
            end
            else
            begin
                ci_next  = ci_last ? '0 : ci_reg + cbmd_pkg::COL_W'(1);
                ri_next  = ri_reg + cbmd_pkg::ROW_W'(ci_last);
                win_next = win_adv;
            end
            if (produce)
            begin
                out_valid_next = 1'b1;
                mask_next      = |acc;
                last_next      = last;
            end
        end
        bypass_valid_next = ram_we && (ram_waddr == ci_next);

        m_tvalid  = out_valid_reg;
        mask      = mask_reg;
        frame_end = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ci_reg           <= '0;
            ri_reg           <= '0;
            win_reg          <= '0;
            out_valid_reg    <= 1'b0;
            bypass_valid_reg <= 1'b0;
        end
        else
        begin
            ci_reg           <= ci_next;
            ri_reg           <= ri_next;
            win_reg          <= win_next;
            out_valid_reg    <= out_valid_next;
            bypass_valid_reg <= bypass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg        <= mask_next;
        last_reg        <= last_next;
        bypass_data_reg <= ram_wdata;
    end

    `ASSERT_ALWAYS(a_col_in_row, ci_reg <= wm1, "column position beyond row width")
    `ASSERT_IMPL(a_repeat_one_row, step && q_item.kind == cbmd_pkg::KIND_DRAIN && !produce, size.height == cbmd_pkg::HEIGHT_W'(1), "drain repeated outside a one-row frame")

endmodule

`default_nettype wire

/* design/color_band_mask_dilate_unit.sv */
// A pixel's result is written with the pixel one row plus one later (or a drain beat after the
// last pixel) and reaches m_tvalid via the queue and output registers. Throughput: one beat per
// cycle unless m_tready holds the output, set by the single port pair of the line memory; a
// one-row frame's first drain steps again. Reset is asynchronous: it resets positions, window,
// queue, output valid and the registers; the line memory is not cleared and needs no pass.
`default_nettype none

module color_band_mask_dilate_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [23:0]                      s_tdata,  // blue, green, red
    input  wire logic [0:0]                       s_tuser,  // kind
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [7:0]                            m_tdata,  // mask, zero padding
    output logic                                  m_tlast,
    input  wire logic                             wr_en,
    input  wire logic [cbmd_pkg::INDEX_W-1:0]     wr_index,
    input  wire logic [cbmd_pkg::SIZE_REG_W-1:0]  wr_data
);

    cbmd_pkg::cbmd_band_t band_reg;
    cbmd_pkg::cbmd_size_t size_reg;
    logic [cbmd_pkg::WIDTH_W-1:0]  width_clamp;
    logic [cbmd_pkg::HEIGHT_W-1:0] height_clamp;
    logic                          restart;

    logic                 q_push, q_ready, q_pop, q_valid;
    cbmd_pkg::cbmd_item_t push_item, pop_item;
    logic                 mask;

    always_comb
    begin
        if (wr_data == '0)
        begin
            width_clamp  = cbmd_pkg::WIDTH_W'(1);
            height_clamp = cbmd_pkg::HEIGHT_W'(1);
        end
        else
        begin
            width_clamp  = (int'(wr_data) > cbmd_pkg::MAX_WIDTH)
                         ? cbmd_pkg::WIDTH_W'(cbmd_pkg::MAX_WIDTH) : cbmd_pkg::WIDTH_W'(wr_data);
            height_clamp = (int'(wr_data) > cbmd_pkg::MAX_HEIGHT)
                         ? cbmd_pkg::HEIGHT_W'(cbmd_pkg::MAX_HEIGHT)
                         : cbmd_pkg::HEIGHT_W'(wr_data);
        end
        restart = wr_en && (wr_index == cbmd_pkg::REG_WIDTH || wr_index == cbmd_pkg::REG_HEIGHT);
        m_tdata = {7'b0, mask};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg.width    <= cbmd_pkg::WIDTH_W'(cbmd_pkg::RESET_WIDTH);
            size_reg.height   <= cbmd_pkg::HEIGHT_W'(cbmd_pkg::RESET_HEIGHT);
            band_reg.b_center <= cbmd_pkg::CHAN_W'(cbmd_pkg::RESET_CENTER);
            band_reg.g_center <= cbmd_pkg::CHAN_W'(cbmd_pkg::RESET_CENTER);
            band_reg.r_center <= cbmd_pkg::CHAN_W'(cbmd_pkg::RESET_CENTER);
            band_reg.b_tol    <= cbmd_pkg::CHAN_W'(cbmd_pkg::RESET_TOL);
            band_reg.g_tol    <= cbmd_pkg::CHAN_W'(cbmd_pkg::RESET_TOL);
            band_reg.r_tol    <= cbmd_pkg::CHAN_W'(cbmd_pkg::RESET_TOL);
        end
        else if (wr_en)
        begin
            case (wr_index)
                cbmd_pkg::REG_WIDTH:    size_reg.width    <= width_clamp;
                cbmd_pkg::REG_HEIGHT:   size_reg.height   <= height_clamp;
                cbmd_pkg::REG_B_CENTER: band_reg.b_center <= wr_data[cbmd_pkg::CHAN_W-1:0];
                cbmd_pkg::REG_G_CENTER: band_reg.g_center <= wr_data[cbmd_pkg::CHAN_W-1:0];
                cbmd_pkg::REG_R_CENTER: band_reg.r_center <= wr_data[cbmd_pkg::CHAN_W-1:0];
                cbmd_pkg::REG_B_TOL:    band_reg.b_tol    <= wr_data[cbmd_pkg::CHAN_W-1:0];
                cbmd_pkg::REG_G_TOL:    band_reg.g_tol    <= wr_data[cbmd_pkg::CHAN_W-1:0];
                cbmd_pkg::REG_R_TOL:    band_reg.r_tol    <= wr_data[cbmd_pkg::CHAN_W-1:0];
                default:                band_reg          <= band_reg;
            endcase
        end
    end

    cbmd_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .band     (band_reg),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    cbmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (push_item),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_item   (pop_item)
    );

    cbmd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .size      (size_reg),
        .restart   (restart),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .mask      (mask),
        .frame_end (m_tlast)
    );

endmodule

`default_nettype wire
